### src/nmea_pfp_pkg.sv
// shared constants, types and power-of-ten helpers for the nmea position field parser
// no dependencies; imported by the core, the coordinate unit and the testbench
`timescale 1ns / 1ps

package nmea_pfp_pkg;

  localparam int unsigned FieldCharsDefault  = 9;
  localparam int unsigned FracDigitsDefault  = 5;
  localparam int unsigned MaxSentenceDefault = 255;

  localparam int unsigned MagW   = 47;
  localparam int unsigned CoordW = 48;
  localparam int unsigned SumW   = MagW + 5;

  localparam logic [MagW-1:0] MagCap = {MagW{1'b1}};

  // characters of interest
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChV     = 8'h56;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // number scan phases
  localparam logic [1:0] PhLead   = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhStop   = 2'd2;

  localparam logic [3:0] FieldMax = 4'hF;

  function automatic logic [MagW-1:0] pow10(input int unsigned n);
    logic [MagW-1:0] v;
    v = MagW'(1);
    for (int unsigned i = 0; i < n; i++) begin
      v = MagW'(v * MagW'(10));
    end
    return v;
  endfunction

  // fraction digit weight picked by a small index
  function automatic logic [MagW-1:0] pow10_sel(input logic [2:0] n);
    logic [MagW-1:0] v;
    unique case (n)
      3'd0: v = MagW'(1);
      3'd1: v = MagW'(10);
      3'd2: v = MagW'(100);
      3'd3: v = MagW'(1000);
      3'd4: v = MagW'(10000);
      3'd5: v = MagW'(100000);
      3'd6: v = MagW'(1000000);
      3'd7: v = MagW'(10000000);
    endcase
    return v;
  endfunction

  // per-character control handed to both coordinate units
  typedef struct packed {
    logic       step;
    logic       clear;
    logic [3:0] field;
    logic [7:0] ch;
  } char_ctl_t;

  typedef struct packed {
    logic [CoordW-1:0] held;
    logic              committed;
  } coord_res_t;

endpackage

### src/nmea_position_field_parser_core.sv
// channel  dir  handshake               payload
// s_axis   in   tvalid/tready, tlast    tdata[7:0] ch, tlast = last
// m_axis   out  tvalid/tready           tdata: latitude, longitude, lat/lon updated, void
//
// one character a cycle unless stalled: input register, state update, result register
// a sentence result appears the cycle after its last character leaves the input register
// rst_ni clears the sentence state, both held coordinates and the valid flags
// a waiting result stalls only a following last character; other characters keep flowing
// depends on nmea_pfp_pkg and nmea_pfp_coord
`timescale 1ns / 1ps

module nmea_position_field_parser_core import nmea_pfp_pkg::*; #(
  parameter int unsigned FIELD_CHARS  = FieldCharsDefault,
  parameter int unsigned FRAC_DIGITS  = FracDigitsDefault,
  parameter int unsigned MAX_SENTENCE = MaxSentenceDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] ch
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata    // [47:0] latitude, [95:48] longitude,
                                       // [96] lat_updated, [97] lon_updated,
                                       // [98] status_void, [103:99] zero
);

  localparam logic [7:0] ByteLimit = 8'(MAX_SENTENCE);

  logic         s1_valid_q;
  logic [7:0]   s1_ch_q;
  logic         s1_last_q;
  logic [7:0]   byte_q;
  logic [3:0]   field_q, field_d;
  logic         void_q, void_d;
  logic         out_valid_q;
  logic [103:0] out_data_q;

  logic       out_free, consume, live, void_hit, in_xfer;
  char_ctl_t  ctl;
  coord_res_t lat_res, lon_res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign consume       = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || consume;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign live = consume && (byte_q < ByteLimit) && !void_q;

  always_comb begin
    field_d = field_q;
    if (live && s1_ch_q == ChComma && field_q != FieldMax) begin
      field_d = field_q + 4'd1;
    end
  end

  assign void_hit = live && (field_d == 4'd1) && (s1_ch_q == ChV);
  assign void_d   = void_q | void_hit;

  assign ctl.step  = live && !void_hit;
  assign ctl.clear = consume && s1_last_q;
  assign ctl.field = field_d;
  assign ctl.ch    = s1_ch_q;

  nmea_pfp_coord #(
    .FIELD_CHARS(FIELD_CHARS),
    .FRAC_DIGITS(FRAC_DIGITS),
    .NUM_FIELD  (2),
    .NEG_LETTER (ChS),
    .POS_LETTER (ChN)
  ) u_lat (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .res_o (lat_res)
  );

  nmea_pfp_coord #(
    .FIELD_CHARS(FIELD_CHARS),
    .FRAC_DIGITS(FRAC_DIGITS),
    .NUM_FIELD  (4),
    .NEG_LETTER (ChW),
    .POS_LETTER (ChE)
  ) u_lon (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .res_o (lon_res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q   <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  // sentence counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      field_q <= '0;
      void_q  <= 1'b0;
    end else if (ctl.clear) begin
      byte_q  <= '0;
      field_q <= '0;
      void_q  <= 1'b0;
    end else if (live) begin
      byte_q  <= byte_q + 8'd1;
      field_q <= field_d;
      void_q  <= void_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.clear) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.clear) begin
      out_data_q <= {5'b0, void_d, lon_res.committed, lat_res.committed,
                     lon_res.held, lat_res.held};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### src/nmea_pfp_coord.sv
// one coordinate unit: number scan of its field and hemisphere commit in the next field
// depends on nmea_pfp_pkg
`timescale 1ns / 1ps

module nmea_pfp_coord import nmea_pfp_pkg::*; #(
  parameter int unsigned FIELD_CHARS = FieldCharsDefault,
  parameter int unsigned FRAC_DIGITS = FracDigitsDefault,
  parameter int unsigned NUM_FIELD   = 2,
  parameter logic [7:0]  NEG_LETTER  = ChS,
  parameter logic [7:0]  POS_LETTER  = ChN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  char_ctl_t  ctl_i,
  output coord_res_t res_o
);

  localparam logic [3:0]      NumFieldC = 4'(NUM_FIELD);
  localparam logic [3:0]      HemFieldC = 4'(NUM_FIELD + 1);
  localparam logic [3:0]      CharLimit = 4'(FIELD_CHARS);
  localparam logic [2:0]      FracLimit = 3'(FRAC_DIGITS);
  localparam logic [2:0]      FracTop   = 3'(FRAC_DIGITS - 1);
  localparam logic [MagW-1:0] IntWeight = pow10(FRAC_DIGITS);

  logic [MagW-1:0]   mag_q, mag_d;
  logic              minus_q, minus_d;
  logic [1:0]        phase_q, phase_d;
  logic              point_q, point_d;
  logic [2:0]        frac_q, frac_d;
  logic [3:0]        cc_q, cc_d;
  logic              comm_q, comm_d;
  logic [CoordW-1:0] held_q, held_d;

  logic            is_digit;
  logic [3:0]      digit;
  logic [2:0]      frac_idx;
  logic [SumW-1:0] int_sum, frac_sum;
  logic [MagW-1:0] int_mag, frac_mag;
  logic            num_sel, hem_sel, num_live, negate;

  assign is_digit = (ctl_i.ch >= ChZero) && (ctl_i.ch <= ChNine);
  assign digit    = ctl_i.ch[3:0];
  assign frac_idx = FracTop - frac_q;

  // integer digit shifts the value one decade up, mag*10 as two shifts
  assign int_sum  = ({5'b0, mag_q} << 3) + ({5'b0, mag_q} << 1)
                  + ({{(SumW-4){1'b0}}, digit} * SumW'(IntWeight));
  assign frac_sum = {5'b0, mag_q}
                  + ({{(SumW-4){1'b0}}, digit} * SumW'(pow10_sel(frac_idx)));
  assign int_mag  = (int_sum > SumW'(MagCap)) ? MagCap : int_sum[MagW-1:0];
  assign frac_mag = (frac_sum > SumW'(MagCap)) ? MagCap : frac_sum[MagW-1:0];

  assign num_sel  = (ctl_i.field == NumFieldC) && (ctl_i.ch != ChComma);
  assign hem_sel  = (ctl_i.field == HemFieldC)
                  && ((ctl_i.ch == NEG_LETTER) || (ctl_i.ch == POS_LETTER));
  assign num_live = (cc_q < CharLimit) && (phase_q != PhStop);
  assign negate   = minus_q ^ (ctl_i.ch == NEG_LETTER);

  always_comb begin
    mag_d   = mag_q;
    minus_d = minus_q;
    phase_d = phase_q;
    point_d = point_q;
    frac_d  = frac_q;
    cc_d    = cc_q;
    comm_d  = comm_q;
    held_d  = held_q;
    if (ctl_i.step && !comm_q) begin
      if (num_sel) begin
        if (num_live) begin
          cc_d = cc_q + 4'd1;
          if (phase_q == PhLead && ctl_i.ch == ChSpace) begin
            phase_d = PhLead;
          end else if (phase_q == PhLead && ctl_i.ch == ChMinus) begin
            phase_d = PhDigits;
            minus_d = 1'b1;
          end else if (phase_q == PhLead && ctl_i.ch == ChPlus) begin
            phase_d = PhDigits;
          end else if (is_digit) begin
            phase_d = PhDigits;
            if (point_q) begin
              if (frac_q < FracLimit) begin
                mag_d  = frac_mag;
                frac_d = frac_q + 3'd1;
              end
            end else begin
              mag_d = int_mag;
            end
          end else if (ctl_i.ch == ChDot) begin
            phase_d = PhDigits;
            point_d = 1'b1;
          end else begin
            phase_d = PhStop;
          end
        end
      end else if (hem_sel) begin
        held_d = negate ? (CoordW'(0) - {1'b0, mag_q}) : {1'b0, mag_q};
        comm_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      minus_q <= 1'b0;
      phase_q <= PhLead;
      point_q <= 1'b0;
      frac_q  <= '0;
      cc_q    <= '0;
      comm_q  <= 1'b0;
      held_q  <= '0;
    end else begin
      held_q <= held_d;
      if (ctl_i.clear) begin
        mag_q   <= '0;
        minus_q <= 1'b0;
        phase_q <= PhLead;
        point_q <= 1'b0;
        frac_q  <= '0;
        cc_q    <= '0;
        comm_q  <= 1'b0;
      end else begin
        mag_q   <= mag_d;
        minus_q <= minus_d;
        phase_q <= phase_d;
        point_q <= point_d;
        frac_q  <= frac_d;
        cc_q    <= cc_d;
        comm_q  <= comm_d;
      end
    end
  end

  // result reflects the character just processed, before the end-of-sentence clear
  assign res_o.held      = held_d;
  assign res_o.committed = comm_d;

endmodule

### src/nmea_pfp_checker.sv
// port-level checker for nmea_position_field_parser_core, bound to the top level
// depends only on the top level's ports
`timescale 1ns / 1ps

module nmea_pfp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [7:0]   s_axis_tdata,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // a waiting input transfer holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
    else $error("input transfer dropped or changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // the input side only stalls behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // a voided sentence never commits a coordinate
  a_void_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[98] |-> !m_axis_tdata[96] && !m_axis_tdata[97])
    else $error("coordinate committed in a voided sentence");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[103:99] == 5'b0)
    else $error("result padding not zero");

endmodule

bind nmea_position_field_parser_core nmea_pfp_checker u_nmea_pfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### verif/tb_nmea_position_field_parser_core.sv
// self-checking testbench for nmea_position_field_parser_core: streams rmc-style sentences
// and compares every fix against an in-bench model of the field scanner
// depends on nmea_pfp_pkg and the core rtl
`timescale 1ns / 1ps

module tb_nmea_position_field_parser_core;
  import nmea_pfp_pkg::*;

  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChX     = 8'h78;
  localparam int         QuietMax = 4000;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } char_item_t;

  typedef struct {
    logic [MagW-1:0]   mag;
    logic              minus;
    logic [1:0]        phase;
    logic              point;
    logic [2:0]        frac;
    logic [3:0]        nchar;
    logic              done;
    logic [CoordW-1:0] held;
  } coord_track_t;

  typedef struct {
    logic [CoordW-1:0] lat;
    logic [CoordW-1:0] lon;
    logic              lat_upd;
    logic              lon_upd;
    logic              void_f;
  } fix_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;  // [7:0] ch
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;          // [47:0] latitude, [95:48] longitude,
                                       // [96] lat_updated, [97] lon_updated,
                                       // [98] status_void

  char_item_t   char_feed[$];
  fix_t         due_fixes[$];
  coord_track_t trk[2];
  logic [3:0]   fld;
  logic [7:0]   nbyte;
  logic         voided;

  bit  sent_now;
  bit  next_drain;
  int  total_chars;
  int  chars_taken;
  int  fixes_seen;
  int  sentences;
  int  errors;
  int  quiet;

  nmea_position_field_parser_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- fix model

  function automatic logic [63:0] ten_to(input int unsigned n);
    logic [63:0] v;
    v = 64'd1;
    repeat (n) v = v * 64'd10;
    return v;
  endfunction

  function automatic void clear_sentence_state();
    fld = '0;
    nbyte = '0;
    voided = 1'b0;
    for (int c = 0; c < 2; c++) begin
      trk[c].mag = '0;
      trk[c].minus = 1'b0;
      trk[c].phase = PhLead;
      trk[c].point = 1'b0;
      trk[c].frac = '0;
      trk[c].nchar = '0;
      trk[c].done = 1'b0;
    end
  endfunction

  function automatic void scan_number_char(input int c, input logic [7:0] ch);
    logic [63:0] acc;
    if (trk[c].nchar >= FieldCharsDefault || trk[c].phase == PhStop) return;
    trk[c].nchar++;
    if (trk[c].phase == PhLead) begin
      if (ch == ChSpace) return;
      trk[c].phase = PhDigits;
      if (ch == ChMinus) begin
        trk[c].minus = 1'b1;
        return;
      end
      if (ch == ChPlus) return;
    end
    if (ch >= ChZero && ch <= ChNine) begin
      acc = 64'(trk[c].mag);
      if (trk[c].point) begin
        // fraction digits past the fixed-point scale are dropped
        if (trk[c].frac < FracDigitsDefault) begin
          acc = acc + 64'(ch - ChZero) * ten_to(FracDigitsDefault - 1 - trk[c].frac);
          trk[c].frac++;
        end
      end else begin
        acc = acc * 64'd10 + 64'(ch - ChZero) * ten_to(FracDigitsDefault);
      end
      trk[c].mag = (acc > 64'(MagCap)) ? MagCap : acc[MagW-1:0];
    end else if (ch == ChDot) begin
      trk[c].point = 1'b1;
    end else begin
      trk[c].phase = PhStop;
    end
  endfunction

  function automatic void hemisphere_char(input int c, input logic [7:0] ch);
    logic neg_l;
    logic [CoordW-1:0] v;
    neg_l = (c == 0) ? (ch == ChS) : (ch == ChW);
    if (!neg_l && ch != ((c == 0) ? ChN : ChE)) return;
    v = CoordW'(trk[c].mag);
    // a minus sign and a south/west letter cancel
    trk[c].held = (trk[c].minus ^ neg_l) ? -v : v;
    trk[c].done = 1'b1;
  endfunction

  function automatic void take_char(input logic [7:0] ch, input logic last);
    fix_t f;
    if (nbyte < MaxSentenceDefault && !voided) begin
      nbyte++;
      if (ch == ChComma && fld < FieldMax) fld++;
      if (fld == 4'd1 && ch == ChV) begin
        voided = 1'b1;
      end else begin
        for (int c = 0; c < 2; c++) begin
          if (!trk[c].done) begin
            if (fld == 4'(2 + 2 * c) && ch != ChComma) scan_number_char(c, ch);
            else if (fld == 4'(3 + 2 * c)) hemisphere_char(c, ch);
          end
        end
      end
    end
    if (last) begin
      f.lat = trk[0].held;
      f.lon = trk[1].held;
      f.lat_upd = trk[0].done;
      f.lon_upd = trk[1].done;
      f.void_f = voided;
      due_fixes.push_back(f);
      clear_sentence_state();
    end
  endfunction

  function automatic void check_fix(input logic [103:0] d);
    fix_t w;
    if (due_fixes.size() == 0) begin
      errors++;
      if (errors <= 10) $display("error: unexpected result %h", d);
      return;
    end
    w = due_fixes.pop_front();
    if (d[47:0] !== w.lat || d[95:48] !== w.lon || d[96] !== w.lat_upd ||
        d[97] !== w.lon_upd || d[98] !== w.void_f) begin
      errors++;
      if (errors <= 10)
        $display("error: fix %0d exp lat %0d lon %0d upd %b%b void %b, got lat %0d lon %0d upd %b%b void %b",
                 fixes_seen, $signed(w.lat), $signed(w.lon), w.lat_upd, w.lon_upd, w.void_f,
                 $signed(d[47:0]), $signed(d[95:48]), d[96], d[97], d[98]);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic put_ch(input logic [7:0] ch);
    char_item_t it;
    it.ch = ch;
    it.last = 1'b0;
    it.drain = next_drain;
    next_drain = 1'b0;
    char_feed.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  task automatic end_sentence();
    char_feed[$].last = 1'b1;
    sentences++;
  endtask

  task automatic put_digits(input int n);
    repeat (n) put_ch(ChZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_coord_field(input int int_digits);
    int kind;
    int r;
    kind = $urandom_range(0, 19);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) put_ch(ChSpace);
    r = $urandom_range(0, 9);
    if (r == 0) put_ch(ChMinus);
    else if (r == 1) put_ch(ChPlus);
    if (kind == 0) return;
    if (kind == 1) begin
      put_digits($urandom_range(9, 14));
      return;
    end
    put_digits($urandom_range(1, int_digits));
    if (kind == 2) put_ch(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) != 0) put_ch(ChDot);
    put_digits($urandom_range(0, 4));
    if (kind == 3) put_ch(ChDot);
    put_digits($urandom_range(0, 4));
  endtask

  task automatic put_hemi(input logic [7:0] neg_l, input logic [7:0] pos_l);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      put_ch($urandom_range(0, 1) ? neg_l : pos_l);
    end else if (r < 90) begin
      put_ch($urandom_range(0, 1) ? neg_l : pos_l);
      put_ch($urandom_range(0, 1) ? neg_l : pos_l);
    end else if (r < 95) begin
      put_ch(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic put_random_sentence(input bit long_one);
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) next_drain = 1'b1;
    if (long_one) begin
      // the longitude lands past the byte limit and must not count
      put_text("$R,A,1234.5,N,");
      repeat (250) put_ch(ChX);
      put_text(",9.9,E");
    end else if (r < 12) begin
      repeat ($urandom_range(1, 30))
        put_ch(($urandom_range(0, 3) == 0) ? ChComma : 8'($urandom_range(0, 255)));
    end else if (r < 15) begin
      repeat ($urandom_range(14, 20)) put_ch(ChComma);
      put_text("VSN");
    end else begin
      put_text($urandom_range(0, 1) ? "$GPRMC," : "$R,");
      put_digits($urandom_range(0, 6));
      put_ch(ChComma);
      r = $urandom_range(0, 99);
      if (r < 80) put_ch(ChA);
      else if (r < 92) put_ch(ChV);
      else if (r < 96) put_text("AV");
      else put_ch(8'($urandom_range(0, 255)));
      put_ch(ChComma);
      put_coord_field(4);
      put_ch(ChComma);
      put_hemi(ChS, ChN);
      put_ch(ChComma);
      put_coord_field(5);
      put_ch(ChComma);
      put_hemi(ChW, ChE);
      if ($urandom_range(0, 2) == 0) put_text(",0.5,,*6A");
    end
    end_sentence();
  endtask

  task automatic build_stimulus();
    int nrand;
    // directed: plain fix, void, sign cancel and truncation, empty field, stray dots,
    // first letter wins, long field, many commas, byte extremes, one-char sentence
    put_text("$R,A,4916.45,N,12311.12,W");        end_sentence();
    next_drain = 1'b1;
    put_text("$R,V,4916.45,N,1.5,E");             end_sentence();
    put_text("$R,A,  -12.5,S,+0.0000199,E");      end_sentence();
    put_text("$R,A,1.2.3,X,4x5,E");               end_sentence();
    put_text("$R,A,-1,NS,,EW");                   end_sentence();
    put_text("$R,A,123456789012,S,99999.999999,E"); end_sentence();
    put_text(",,,,,,,,,,,,,,,,,,V");
    put_ch(8'h00);
    put_ch(8'hFF);
    end_sentence();
    put_ch(ChX);                                  end_sentence();
    nrand = 0;
    while (char_feed.size() < 1050 || sentences < 45) begin
      put_random_sentence(nrand == 4);
      nrand++;
    end
  endtask

  // ---------------------------------------------------------------- idling

  function automatic int idle_mode();
    if (chars_taken < total_chars / 3) return 0;
    if (chars_taken < 2 * total_chars / 3) return 1;
    return 2;
  endfunction

  function automatic bit sender_rest();
    case (idle_mode())
      0: return $urandom_range(0, 99) < 35;
      1: return $urandom_range(0, 99) < 59;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_rest();
    case (idle_mode())
      0: return $urandom_range(0, 99) < 59;
      1: return $urandom_range(0, 99) < 35;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin : feed
    char_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || sent_now) begin
        sent_now = 1'b0;
        // a drain-marked sentence waits until every fix has been taken
        if (char_feed.size() != 0 && !(char_feed[0].drain && due_fixes.size() != 0) &&
            !sender_rest()) begin
          nxt = char_feed.pop_front();
          s_axis_tdata <= nxt.ch;
          s_axis_tlast <= nxt.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !receiver_rest();
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : watch
    if (rst_ni) begin
      quiet++;
      if (m_axis_tvalid && m_axis_tready) begin
        check_fix(m_axis_tdata);
        fixes_seen++;
        quiet = 0;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_char(s_axis_tdata, s_axis_tlast);
        chars_taken++;
        sent_now = 1'b1;
        quiet = 0;
      end
      if (quiet >= QuietMax) begin
        $display("error: no transfer for %0d cycles", QuietMax);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    trk[0].held = '0;
    trk[1].held = '0;
    clear_sentence_state();
    build_stimulus();
    total_chars = char_feed.size();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (char_feed.size() != 0 || s_axis_tvalid || due_fixes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("summary: %0d characters in %0d sentences, %0d fixes checked, %0d mismatches",
             chars_taken, sentences, fixes_seen, errors);
    $display("  covered void, sign and hemisphere, truncation, long field and long sentence");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
